[hw/rtl/cbn_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cbn_pkg: shared types and constants for the coverage bucket block
// Beat formats, map sizing, queue sizing and the hit-count bucketing table.
// ----------------------------------------------------------------------------
package cbn_pkg;

  localparam int unsigned MAP_ENTRIES = 65536;
  localparam int unsigned ADDR_W      = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]  hit_count;
    logic [15:0] entry_index;
    logic        last_of_run;
  } cbn_in_t;

  typedef struct packed {
    logic [7:0] bucket_value;
    logic       entry_was_new;
    logic       run_has_new;
    logic       run_done;
  } cbn_out_t;

  // Classified item as it sits in the queue between front and back.
  typedef struct packed {
    logic [7:0]        bucket;
    logic [ADDR_W-1:0] addr;
    logic              in_range;
    logic              last;
  } cbn_item_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic full;
    logic empty;
  } cbn_qstat_t;

  // Back end status seen by the front end.
  typedef struct packed {
    logic clearing;
  } cbn_bstat_t;

  function automatic logic [7:0] bucket_of(input logic [7:0] c);
    case (c) inside
      8'd0, 8'd1, 8'd2: return c;
      8'd3:             return 8'd4;
      [8'd4:8'd7]:      return 8'd8;
      [8'd8:8'd15]:     return 8'd16;
      [8'd16:8'd31]:    return 8'd32;
      [8'd32:8'd127]:   return 8'd64;
      default:          return 8'd128;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [15:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[ADDR_W-1:0];
  endfunction

  function automatic logic idx_in_range(input logic [15:0] idx);
    return 32'(idx) < MAP_ENTRIES;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/coverage_hit_bucket_novelty_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// coverage_hit_bucket_novelty_top: hit-count bucketing with first-seen map
// Buckets each edge hit count and flags entries covered for the first time,
// with a per-run new-coverage flag.
// ----------------------------------------------------------------------------
//  Port group  Dir  Payload     Handshake
//  in_*        in   cbn_in_t    in_valid / in_ready
//  out_*       out  cbn_out_t   out_valid / out_ready
//
// One beat per cycle sustained while the output side does not stall; a taken
// beat passes through the queue, the map read and then the output register
// before out_valid rises.
// After reset the map is cleared one entry a cycle, all MAP_ENTRIES entries,
// with in_ready low throughout.
// The four-entry queue lets the input side keep accepting while the output
// side stalls; in_ready drops only when the queue is full or the map is being cleared.
module coverage_hit_bucket_novelty_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cbn_pkg::cbn_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cbn_pkg::cbn_out_t      out_data
);
  import cbn_pkg::*;

  logic       push;
  cbn_item_t  push_item;
  logic       pop;
  cbn_item_t  head_item;
  cbn_qstat_t qstat;
  cbn_bstat_t bstat;

  cbn_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .qstat     (qstat),
    .bstat     (bstat),
    .push      (push),
    .push_item (push_item)
  );

  cbn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (qstat)
  );

  cbn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .qstat     (qstat),
    .pop       (pop),
    .bstat     (bstat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[hw/rtl/cbn_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cbn_ram: generic simple dual-port RAM
// One write port, one read port with registered read data (old data on a
// same-address write).
// ----------------------------------------------------------------------------
module cbn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[hw/rtl/cbn_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cbn_queue: short item queue between front and back
// Flop-based FIFO of classified items; full and empty are decoded from a registered count.
// ----------------------------------------------------------------------------
module cbn_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire cbn_pkg::cbn_item_t push_item,
  input  wire logic               pop,
  output cbn_pkg::cbn_item_t      head_item,
  output cbn_pkg::cbn_qstat_t     stat
);
  import cbn_pkg::*;

  cbn_item_t         slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item  = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule
`default_nettype wire

[hw/rtl/cbn_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cbn_front: input beat acceptance and classification
// Buckets the raw hit count, checks the index against the map size and
// pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module cbn_front (
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cbn_pkg::cbn_in_t    in_data,
  input  wire cbn_pkg::cbn_qstat_t qstat,
  input  wire cbn_pkg::cbn_bstat_t bstat,
  output logic                     push,
  output cbn_pkg::cbn_item_t       push_item
);
  import cbn_pkg::*;

  // No beats are taken while the map is being cleared after reset.
  assign in_ready = !qstat.full && !bstat.clearing;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.bucket   = bucket_of(in_data.hit_count);
    push_item.addr     = addr_of(in_data.entry_index);
    push_item.in_range = idx_in_range(in_data.entry_index);
    push_item.last     = in_data.last_of_run;
  end

endmodule
`default_nettype wire

[hw/rtl/cbn_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cbn_back: coverage map update and result output
// Clears the map after reset, then reads the map for each queued item,
// decides whether the entry is new, marks new entries and registers the result beat.
// ----------------------------------------------------------------------------
module cbn_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cbn_pkg::cbn_item_t  head_item,
  input  wire cbn_pkg::cbn_qstat_t qstat,
  output logic                     pop,
  output cbn_pkg::cbn_bstat_t      bstat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cbn_pkg::cbn_out_t        out_data
);
  import cbn_pkg::*;

  logic              clearing_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic              s2_valid_r;
  cbn_item_t         s2_item_r;
  logic              s2_fire;

  logic              lw_valid_r;
  logic [ADDR_W-1:0] lw_addr_r;

  logic              run_new_r;
  logic              out_valid_r;
  cbn_out_t          out_data_r;

  logic              rd_seen;
  logic              seen;
  logic              is_new;
  logic              run_flag;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [0:0]        ram_wdata;
  logic [0:0]        ram_rdata;

  // Only the seen bit matters: an entry is never changed once nonzero.
  cbn_ram #(
    .WIDTH (1),
    .DEPTH (MAP_ENTRIES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pop),
    .raddr (head_item.addr),
    .rdata (ram_rdata)
  );

  assign s2_fire = s2_valid_r && (!out_valid_r || out_ready);
  assign pop     = !qstat.empty && !clearing_r && (!s2_valid_r || s2_fire);

  // A read issued in the same cycle as a write to that entry returns the
  // old bit, so the last written address is forwarded. Seen bits only ever
  // go from zero to one, so forwarding an older write is always safe.
  assign rd_seen  = ram_rdata[0];
  assign seen     = rd_seen || (lw_valid_r && (lw_addr_r == s2_item_r.addr));
  assign is_new   = s2_item_r.in_range && (s2_item_r.bucket != '0) && !seen;
  assign run_flag = run_new_r || is_new;

  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = s2_fire && is_new;
      ram_waddr = s2_item_r.addr;
      ram_wdata = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s2_valid_r  <= 1'b0;
      lw_valid_r  <= 1'b0;
      run_new_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(MAP_ENTRIES - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (pop) begin
        s2_valid_r <= 1'b1;
      end else if (s2_fire) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_fire) begin
        out_valid_r <= 1'b1;
        run_new_r   <= s2_item_r.last ? 1'b0 : run_flag;
        if (is_new) begin
          lw_valid_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_item_r <= head_item;
    end
    if (s2_fire) begin
      out_data_r.bucket_value  <= s2_item_r.bucket;
      out_data_r.entry_was_new <= is_new;
      out_data_r.run_has_new   <= run_flag;
      out_data_r.run_done      <= s2_item_r.last;
      if (is_new) begin
        lw_addr_r <= s2_item_r.addr;
      end
    end
  end

  assign bstat.clearing = clearing_r;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

endmodule
`default_nettype wire

[bench/coverage_hit_bucket_novelty_top_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// coverage_hit_bucket_novelty_top_tb: regression bench for the coverage block
// Sends a directed table of hit counts and then random runs of map entries,
// with random idling on both sides. Typed directed rows are checked against fixed
// results; all other beats against a local model of bucketing, first-seen map and run flag.
// ----------------------------------------------------------------------------
module coverage_hit_bucket_novelty_top_tb;
  import cbn_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_BEATS = 750;
  localparam int IDLE_PCT     = 37;
  localparam int STEADY_FIRST = 300;
  localparam int STEADY_LAST  = 449;
  localparam int PAUSE_AT     = 550;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOT_ENTRIES  = 24;
  // The clearing pass alone walks all MAP_ENTRIES entries; this leaves plenty of room.
  localparam int RUN_LIMIT    = 5_000_000;

  typedef struct packed {
    logic [7:0]  hit_count;
    logic [15:0] entry_index;
    logic        last_of_run;
    logic        typed;
    logic [7:0]  bucket;
    logic        was_new;
    logic        run_new;
  } directed_row_t;

  // Rows with typed set carry a result read straight off the bucketing rules.
  localparam directed_row_t DIRECTED [20] = '{
    '{8'd0,   16'h0000, 1'b0, 1'b1, 8'd0,   1'b0, 1'b0},
    '{8'd1,   16'h0000, 1'b0, 1'b1, 8'd1,   1'b1, 1'b1},
    '{8'd255, 16'h0000, 1'b0, 1'b1, 8'd128, 1'b0, 1'b1},
    '{8'd2,   16'hFFFF, 1'b1, 1'b1, 8'd2,   1'b1, 1'b1},
    '{8'd3,   16'hFFFF, 1'b0, 1'b1, 8'd4,   1'b0, 1'b0},
    '{8'd4,   16'h5555, 1'b0, 1'b1, 8'd8,   1'b1, 1'b1},
    '{8'd7,   16'hAAAA, 1'b1, 1'b1, 8'd8,   1'b1, 1'b1},
    '{8'd0,   16'h1234, 1'b1, 1'b1, 8'd0,   1'b0, 1'b0},
    '{8'd0,   16'hFFFF, 1'b1, 1'b1, 8'd0,   1'b0, 1'b0},
    '{8'd8,   16'h0001, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{8'd15,  16'h0002, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{8'd16,  16'h0004, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{8'd31,  16'h0008, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{8'd32,  16'h0010, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{8'd127, 16'h0020, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{8'd128, 16'h0040, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{8'd255, 16'h0080, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
    '{8'd128, 16'h0001, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
    '{8'd1,   16'hFF00, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{8'd254, 16'h00FF, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  cbn_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cbn_out_t out_data;

  logic [7:0]  covered_map [MAP_ENTRIES];
  logic        run_flag_model;
  logic [15:0] hot_index [HOT_ENTRIES];
  cbn_out_t    pending_results [$];
  int          error_count  = 0;
  int          result_count = 0;
  bit          no_idle      = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  coverage_hit_bucket_novelty_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  function automatic logic [7:0] bucket_for_count(input logic [7:0] cnt);
    if (cnt <= 8'd2) return cnt;
    if (cnt == 8'd3) return 8'd4;
    if (cnt <= 8'd7) return 8'd8;
    if (cnt <= 8'd15) return 8'd16;
    if (cnt <= 8'd31) return 8'd32;
    if (cnt <= 8'd127) return 8'd64;
    return 8'd128;
  endfunction

  // Advances the local map and run flag by one beat and returns its result.
  function automatic cbn_out_t predict_coverage(input cbn_in_t beat);
    cbn_out_t res;
    res.bucket_value  = bucket_for_count(beat.hit_count);
    res.entry_was_new = 1'b0;
    if (32'(beat.entry_index) < MAP_ENTRIES && res.bucket_value != 8'd0 &&
        covered_map[beat.entry_index] == 8'd0) begin
      covered_map[beat.entry_index] = res.bucket_value;
      res.entry_was_new = 1'b1;
    end
    res.run_has_new = run_flag_model | res.entry_was_new;
    res.run_done    = beat.last_of_run;
    run_flag_model  = beat.last_of_run ? 1'b0 : res.run_has_new;
    return res;
  endfunction

  function automatic cbn_in_t random_beat(input logic last);
    cbn_in_t beat;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      beat.entry_index = hot_index[$urandom_range(0, HOT_ENTRIES - 1)];
    end else if (pick == 4) begin
      beat.entry_index = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end else begin
      beat.entry_index = 16'($urandom_range(0, 65535));
    end
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      beat.hit_count = 8'd0;
    end else if (pick < 6) begin
      beat.hit_count = 8'($urandom_range(1, 7));
    end else begin
      beat.hit_count = 8'($urandom_range(0, 255));
    end
    beat.last_of_run = last;
    return beat;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH: %s", what);
    error_count++;
  endtask

  // Offers one beat after a random gap and records its result once taken.
  task automatic send_beat(input cbn_in_t beat, input logic typed, input cbn_out_t fixed);
    int gap;
    cbn_out_t predicted;
    gap = 0;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!(rst_n && in_ready === 1'b1));
    predicted = predict_coverage(beat);
    pending_results.push_back(typed ? fixed : predicted);
  endtask

  task automatic wait_for_drain();
    if (pending_results.size() != 0) begin
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : watch_results
    cbn_out_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                  result_count));
      end else begin
        want = pending_results.pop_front();
        if (out_data.bucket_value !== want.bucket_value)
          report_mismatch($sformatf("beat %0d bucket_value got %0d expected %0d",
                                    result_count, out_data.bucket_value, want.bucket_value));
        if (out_data.entry_was_new !== want.entry_was_new)
          report_mismatch($sformatf("beat %0d entry_was_new got %b expected %b",
                                    result_count, out_data.entry_was_new, want.entry_was_new));
        if (out_data.run_has_new !== want.run_has_new)
          report_mismatch($sformatf("beat %0d run_has_new got %b expected %b",
                                    result_count, out_data.run_has_new, want.run_has_new));
        if (out_data.run_done !== want.run_done)
          report_mismatch($sformatf("beat %0d run_done got %b expected %b",
                                    result_count, out_data.run_done, want.run_done));
      end
      result_count++;
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("coverage_hit_bucket_novelty_top regression: fail");
    $finish;
  end

  initial begin
    directed_row_t row;
    int sent;
    int run_len;
    bit ragged;
    logic last;
    for (int i = 0; i < MAP_ENTRIES; i++) covered_map[i] = 8'd0;
    run_flag_model = 1'b0;
    for (int i = 0; i < HOT_ENTRIES; i++) hot_index[i] = 16'($urandom_range(0, 65535));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      send_beat(cbn_in_t'{row.hit_count, row.entry_index, row.last_of_run}, row.typed,
                cbn_out_t'{row.bucket, row.was_new, row.run_new, row.last_of_run});
    end
    wait_for_drain();

    // Most runs end on a last beat; about one in ten is ragged, with marks anywhere.
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      run_len = $urandom_range(1, 30);
      ragged  = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < run_len && sent < RANDOM_BEATS; k++) begin
        no_idle = (sent >= STEADY_FIRST && sent <= STEADY_LAST);
        if (sent == PAUSE_AT) wait_for_drain();
        last = ragged ? logic'($urandom_range(0, 1)) : logic'(k == run_len - 1);
        send_beat(random_beat(last), 1'b0, '0);
        sent++;
      end
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("coverage_hit_bucket_novelty_top regression: pass");
    end else begin
      $display("coverage_hit_bucket_novelty_top regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
